FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag a condition that must never be true out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// Require cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/fms_pkg.sv
package fms_pkg;

    localparam int MAX_FEATURES = 4096;
    localparam int MAX_LATENT   = 16;
    localparam int FEAT_W       = $clog2(MAX_FEATURES);
    localparam int LAT_W        = $clog2(MAX_LATENT);
    localparam int KK_W         = LAT_W + 1;

    // Opcodes of an input beat
    localparam logic [1:0] OP_LOAD_LIN = 2'd0;
    localparam logic [1:0] OP_LOAD_LAT = 2'd1;
    localparam logic [1:0] OP_FEATURE  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FEATURE_COUNT = 2'd0;
    localparam logic [1:0] CFG_LATENT_IN_USE = 2'd1;
    localparam logic [1:0] CFG_BIAS          = 2'd2;

    // Multiply operations of the shared multiplier
    localparam logic [2:0] MOP_WX = 3'd0;
    localparam logic [2:0] MOP_VX = 3'd1;
    localparam logic [2:0] MOP_PP = 3'd2;
    localparam logic [2:0] MOP_SS = 3'd3;
    localparam logic [2:0] MOP_II = 3'd4;
    localparam logic [2:0] MOP_LI = 3'd5;
    localparam logic [2:0] MOP_TI = 3'd6;

    // Right shift applied after a multiply
    localparam logic [1:0] SH_16 = 2'd0;
    localparam logic [1:0] SH_31 = 2'd1;
    localparam logic [1:0] SH_32 = 2'd2;

    localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};

    typedef struct packed {
        logic              accept;
        logic              rd_lin;
        logic              rd_lat;
        logic              start;
        logic [2:0]        mop;
        logic [LAT_W-1:0]  f;
        logic              emit;
    } t_cmd;

    typedef struct packed {
        logic              done;
        logic              in_range;
        logic              last;
        logic [KK_W-1:0]   kk;
        logic              out_free;
    } t_stat;

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

    function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a - b;
        if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
        return s;
    endfunction

endpackage

FILE: src/fms_ram.sv
module fms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/fms_mul.sv
`include "assert_macros.svh"

module fms_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_a,
    input  logic signed [63:0] i_b,
    input  logic [1:0]         i_sh,
    output logic               o_done,
    output logic signed [63:0] o_res
);
    import fms_pkg::*;

    logic [63:0]        r_ma, r_mb;
    logic               r_neg;
    logic [1:0]         r_sh;
    logic [127:0]       r_acc;
    logic [2:0]         r_step;
    logic               r_busy;
    logic               r_done;
    logic signed [63:0] r_res;

    logic [31:0]        half_a, half_b;
    logic [63:0]        pp;
    logic [127:0]       pp_sh;
    logic               ovf;
    logic [63:0]        mag;
    logic signed [63:0] n_res;

    // One 32x32 partial product per step
    always_comb begin
        half_a = r_step[1] ? r_ma[63:32] : r_ma[31:0];
        half_b = r_step[0] ? r_mb[63:32] : r_mb[31:0];
        pp     = {32'b0, half_a} * {32'b0, half_b};
        case ({1'b0, r_step[1]} + {1'b0, r_step[0]})
            2'd0:    pp_sh = {64'b0, pp};
            2'd1:    pp_sh = {32'b0, pp, 32'b0};
            default: pp_sh = {pp, 64'b0};
        endcase
    end

    // Shift, truncate toward zero, saturate to 64 bits
    always_comb begin
        case (r_sh)
            SH_16: begin
                ovf = |r_acc[127:80];
                mag = r_acc[79:16];
            end
            SH_31: begin
                ovf = |r_acc[127:95];
                mag = r_acc[94:31];
            end
            default: begin
                ovf = |r_acc[127:96];
                mag = r_acc[95:32];
            end
        endcase
        if (ovf || mag[63]) begin
            n_res = r_neg ? S64_MIN : S64_MAX;
        end else if (r_neg) begin
            n_res = -$signed(mag);
        end else begin
            n_res = $signed(mag);
        end
    end

    // Control of the step sequence
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 3'd4) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 3'd1;
            end
        end
    end

    // Operand magnitudes, accumulator and result
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_sh  <= i_sh;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_step == 3'd4) begin
                r_res <= n_res;
            end else begin
                r_acc <= r_acc + pp_sh;
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_NEVER(a_no_restart, i_clk, i_rst_n, i_start && r_busy,
        "multiplier started while busy")
    `ASSERT_NEXT(a_done_follows, i_clk, i_rst_n, r_busy && r_step == 3'd4 && !i_start,
        r_done && !r_busy, "multiplier finish step did not raise done")

endmodule

FILE: src/fms_dp.sv
`include "assert_macros.svh"

module fms_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fms_pkg::t_cmd       i_cmd,
    output fms_pkg::t_stat      o_stat,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    input  logic [1:0]          i_opcode,
    input  logic [11:0]         i_feature_id,
    input  logic [3:0]          i_latent_slot,
    input  logic signed [31:0]  i_value,
    input  logic [31:0]         i_norm_scale,
    input  logic                i_last,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [31:0]  o_score,
    output logic                o_saturated
);
    import fms_pkg::*;

    // Configuration
    logic [12:0]        r_feature_count;
    logic [4:0]         r_latent_in_use;
    logic signed [31:0] r_bias;

    // Latched feature beat
    logic [FEAT_W-1:0]  r_id;
    logic signed [31:0] r_x;
    logic [31:0]        r_inv;
    logic               r_last;

    // Accumulators and intermediate terms
    logic signed [63:0] r_lin_sum;
    logic signed [63:0] r_fsum [MAX_LATENT];
    logic signed [63:0] r_qsum [MAX_LATENT];
    logic signed [63:0] r_p;
    logic signed [63:0] r_total;
    logic signed [63:0] r_inv2;
    logic signed [63:0] r_lin_t;
    logic signed [63:0] r_fac_t;

    // Output register
    logic               r_out_valid;
    logic signed [31:0] r_score;
    logic               r_sat;

    logic [31:0]        lin_rdata, lat_rdata;
    logic signed [63:0] mul_a, mul_b, mul_res;
    logic [1:0]         mul_sh;
    logic               mul_done;
    logic signed [63:0] sum;
    logic               sum_sat;
    logic               wr_lin, wr_lat;

    assign wr_lin = i_cmd.accept && i_opcode == OP_LOAD_LIN;
    assign wr_lat = i_cmd.accept && i_opcode == OP_LOAD_LAT;

    fms_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_lin_ram (
        .i_clk   (i_clk),
        .i_we    (wr_lin),
        .i_waddr (i_feature_id),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_lin),
        .i_raddr (r_id),
        .o_rdata (lin_rdata)
    );

    fms_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES * MAX_LATENT)) u_lat_ram (
        .i_clk   (i_clk),
        .i_we    (wr_lat),
        .i_waddr ({i_feature_id, i_latent_slot}),
        .i_wdata (i_value),
        .i_re    (i_cmd.rd_lat),
        .i_raddr ({r_id, i_cmd.f}),
        .o_rdata (lat_rdata)
    );

    // Select multiplier operands and shift
    always_comb begin
        case (i_cmd.mop)
            MOP_WX: begin
                mul_a  = 64'(signed'(lin_rdata));
                mul_b  = 64'(r_x);
                mul_sh = SH_16;
            end
            MOP_VX: begin
                mul_a  = 64'(signed'(lat_rdata));
                mul_b  = 64'(r_x);
                mul_sh = SH_16;
            end
            MOP_PP: begin
                mul_a  = r_p;
                mul_b  = r_p;
                mul_sh = SH_16;
            end
            MOP_SS: begin
                mul_a  = r_fsum[i_cmd.f];
                mul_b  = r_fsum[i_cmd.f];
                mul_sh = SH_16;
            end
            MOP_II: begin
                mul_a  = {32'b0, r_inv};
                mul_b  = {32'b0, r_inv};
                mul_sh = SH_31;
            end
            MOP_LI: begin
                mul_a  = r_lin_sum;
                mul_b  = {32'b0, r_inv};
                mul_sh = SH_31;
            end
            default: begin
                mul_a  = r_total;
                mul_b  = r_inv2;
                mul_sh = SH_32;
            end
        endcase
    end

    fms_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .i_sh    (mul_sh),
        .o_done  (mul_done),
        .o_res   (mul_res)
    );

    // Final combine and clip to 32 bits
    always_comb begin
        sum     = sat_add64(sat_add64(64'(r_bias), r_lin_t), r_fac_t);
        sum_sat = !(&sum[63:31] || ~|sum[63:31]);
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feature_count <= '0;
            r_latent_in_use <= 5'd8;
            r_bias          <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FEATURE_COUNT: r_feature_count <= i_cfg_data[12:0];
                CFG_LATENT_IN_USE: r_latent_in_use <= i_cfg_data[4:0];
                CFG_BIAS:          r_bias          <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // Capture the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_id   <= i_feature_id;
            r_x    <= i_value;
            r_inv  <= i_norm_scale;
            r_last <= i_last;
        end
    end

    // Accumulate multiplier results; clear on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit) begin
            r_lin_sum <= '0;
            r_total   <= '0;
            for (int k = 0; k < MAX_LATENT; k++) begin
                r_fsum[k] <= '0;
                r_qsum[k] <= '0;
            end
        end else if (mul_done) begin
            case (i_cmd.mop)
                MOP_WX: r_lin_sum <= sat_add64(r_lin_sum, mul_res);
                MOP_VX: r_p <= mul_res;
                MOP_PP: begin
                    r_fsum[i_cmd.f] <= sat_add64(r_fsum[i_cmd.f], r_p);
                    r_qsum[i_cmd.f] <= sat_add64(r_qsum[i_cmd.f], mul_res);
                end
                MOP_SS: r_total <= sat_add64(r_total, sat_sub64(mul_res, r_qsum[i_cmd.f]));
                MOP_II: r_inv2 <= mul_res;
                MOP_LI: r_lin_t <= mul_res;
                default: r_fac_t <= mul_res;
            endcase
        end
    end

    // Output register: load on emit, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_sat   <= sum_sat;
            r_score <= sum_sat ? (sum[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum[31:0];
        end
    end

    always_comb begin
        o_stat          = '0;
        o_stat.done     = mul_done;
        o_stat.in_range = {1'b0, r_id} < r_feature_count;
        o_stat.last     = r_last;
        o_stat.kk       = (r_latent_in_use > 5'(MAX_LATENT)) ? KK_W'(MAX_LATENT)
                                                               : KK_W'(r_latent_in_use);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_score;
    assign o_saturated = r_sat;

    `ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, i_cmd.emit, r_out_valid,
        "score emitted but output not valid")

endmodule

FILE: src/fms_ctrl.sv
module fms_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [1:0]     i_opcode,
    input  fms_pkg::t_stat i_stat,
    output fms_pkg::t_cmd  o_cmd
);
    import fms_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_RDL  = 3'd2;
    localparam logic [2:0] S_RDV  = 3'd3;
    localparam logic [2:0] S_GO   = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]      r_state, n_state;
    logic [2:0]      r_mop, n_mop;
    logic [KK_W-1:0] r_f, n_f;
    logic [2:0]      af_state, af_mop;
    logic [KK_W-1:0] f_inc;
    logic            accept;

    assign o_in_ready = r_state == S_IDLE;
    assign accept     = i_in_valid && o_in_ready;
    assign f_inc      = r_f + KK_W'(1);

    // Where to go once a feature's sums are updated
    always_comb begin
        if (!i_stat.last) begin
            af_state = S_IDLE;
            af_mop   = r_mop;
        end else begin
            af_state = S_GO;
            af_mop   = (i_stat.kk == '0) ? MOP_II : MOP_SS;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mop        = r_mop;
        n_f          = r_f;
        o_cmd        = '0;
        o_cmd.accept = accept;
        o_cmd.mop    = r_mop;
        o_cmd.f      = r_f[LAT_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (accept && i_opcode == OP_FEATURE) n_state = S_CHK;
            end
            S_CHK: begin
                if (i_stat.in_range) begin
                    n_state = S_RDL;
                end else begin
                    n_state = af_state;
                    n_mop   = af_mop;
                    n_f     = '0;
                end
            end
            S_RDL: begin
                o_cmd.rd_lin = 1'b1;
                n_mop        = MOP_WX;
                n_state      = S_GO;
            end
            S_RDV: begin
                o_cmd.rd_lat = 1'b1;
                n_mop        = MOP_VX;
                n_state      = S_GO;
            end
            S_GO: begin
                o_cmd.start = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                if (i_stat.done) begin
                    case (r_mop)
                        MOP_WX: begin
                            n_f = '0;
                            if (i_stat.kk == '0) begin
                                n_state = af_state;
                                n_mop   = af_mop;
                            end else begin
                                n_state = S_RDV;
                            end
                        end
                        MOP_VX: begin
                            n_mop   = MOP_PP;
                            n_state = S_GO;
                        end
                        MOP_PP: begin
                            if (f_inc < i_stat.kk) begin
                                n_f     = f_inc;
                                n_state = S_RDV;
                            end else begin
                                n_f     = '0;
                                n_state = af_state;
                                n_mop   = af_mop;
                            end
                        end
                        MOP_SS: begin
                            n_state = S_GO;
                            if (f_inc < i_stat.kk) begin
                                n_f = f_inc;
                            end else begin
                                n_mop = MOP_II;
                            end
                        end
                        MOP_II: begin
                            n_mop   = MOP_LI;
                            n_state = S_GO;
                        end
                        MOP_LI: begin
                            n_mop   = MOP_TI;
                            n_state = S_GO;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mop   <= MOP_WX;
            r_f     <= '0;
        end else begin
            r_state <= n_state;
            r_mop   <= n_mop;
            r_f     <= n_f;
        end
    end

endmodule

FILE: src/factorization_machine_score.sv
// Loads (linear or latent weight) and ignored opcodes leave the block ready. A
// feature item holds o_in_ready low while an in-range id runs a weight product
// and latent and square products per factor in use; the last item adds the final
// terms. All products share one 64x64 multiplier of four 32x32 partial products.
// Synchronous active-low reset clears configuration, sums and control state;
// the weight memories hold no reset value and must be loaded before use.
module factorization_machine_score (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [11:0]        i_feature_id,
    input  logic [3:0]         i_latent_slot,
    input  logic signed [31:0] i_value,
    input  logic [31:0]        i_norm_scale,
    input  logic               i_last,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_score,
    output logic               o_saturated
);
    import fms_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fms_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_opcode      (i_opcode),
        .i_feature_id  (i_feature_id),
        .i_latent_slot (i_latent_slot),
        .i_value       (i_value),
        .i_norm_scale  (i_norm_scale),
        .i_last        (i_last),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_score       (o_score),
        .o_saturated   (o_saturated)
    );

endmodule
